// File: sv/i2cbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cbb_pkg;

  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_STOP     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_SEND_ACK = 3'd4;
  localparam logic [2:0] CMD_READ_ACK = 3'd5;

  // index of the final pin write of each command
  localparam logic [4:0] START_LAST = 5'd3;
  localparam logic [4:0] STOP_LAST  = 5'd2;
  localparam logic [4:0] WRITE_LAST = 5'd23;
  localparam logic [4:0] READ_LAST  = 5'd16;
  localparam logic [4:0] ACK_LAST   = 5'd2;

  // one queued bus command, receive data already formed
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx;
    logic       ack;
    logic [7:0] rx;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/i2cbb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface i2cbb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       ack_out;
  logic [7:0] sda_samples;

  modport source (output valid, func, tx_byte, ack_out, sda_samples, input ready);
  modport sink (input valid, func, tx_byte, ack_out, sda_samples, output ready);
endinterface

interface i2cbb_pin_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] rx_data;
  logic       last;

  modport source (output valid, scl_level, sda_level, rx_data, last, input ready);
  modport sink (input valid, scl_level, sda_level, rx_data, last, output ready);
endinterface
`default_nettype wire

// File: sv/i2cbb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_front (
  i2cbb_cmd_if.sink          in_cmd,
  input  wire logic          q_full,
  output logic               push,
  output i2cbb_pkg::cmd_t    push_data
);

  logic known;

  always_comb begin
    push_data.func = in_cmd.func;
    push_data.tx   = in_cmd.tx_byte;
    push_data.ack  = in_cmd.ack_out;
    push_data.rx   = 8'd0;
    known          = 1'b1;
    unique case (in_cmd.func) inside
      i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_STOP, i2cbb_pkg::CMD_WRITE,
      i2cbb_pkg::CMD_SEND_ACK: begin
        push_data.rx = 8'd0;
      end
      i2cbb_pkg::CMD_READ: begin
        push_data.rx = in_cmd.sda_samples;
      end
      i2cbb_pkg::CMD_READ_ACK: begin
        push_data.rx = {7'd0, in_cmd.sda_samples[7]};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // undefined codes are taken and dropped
  assign in_cmd.ready = !q_full;
  assign push         = in_cmd.valid && !q_full && known;

endmodule
`default_nettype wire

// File: sv/i2cbb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire i2cbb_pkg::cmd_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output i2cbb_pkg::cmd_t      q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cbb_pkg::cmd_t   entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/i2cbb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire i2cbb_pkg::cmd_t q_data,
  output logic                 pop,
  i2cbb_pin_if.source          out_pin
);

  logic [4:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] tx_sh_r, tx_sh_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       last_r, last_nxt;

  logic       fire;
  logic       is_scl;
  logic       pin_val;
  logic       is_last;
  logic [7:0] tx_sel;

  assign fire   = q_valid && (!out_valid_r || out_pin.ready);
  assign tx_sel = (step_r == 5'd0) ? q_data.tx : tx_sh_r;

  // which pin this step writes and to what level
  always_comb begin
    is_scl  = 1'b0;
    pin_val = 1'b1;
    is_last = 1'b0;
    unique case (q_data.func) inside
      i2cbb_pkg::CMD_START: begin
        is_scl  = step_r[0];
        pin_val = !step_r[1];
        is_last = (step_r == i2cbb_pkg::START_LAST);
      end
      i2cbb_pkg::CMD_STOP: begin
        is_scl  = step_r[0];
        pin_val = (step_r != 5'd0);
        is_last = (step_r == i2cbb_pkg::STOP_LAST);
      end
      i2cbb_pkg::CMD_WRITE: begin
        is_scl  = (phase_r != 2'd0);
        pin_val = (phase_r == 2'd0) ? tx_sel[7] : (phase_r == 2'd1);
        is_last = (step_r == i2cbb_pkg::WRITE_LAST);
      end
      i2cbb_pkg::CMD_READ: begin
        is_scl  = (step_r != 5'd0);
        pin_val = (step_r == 5'd0) || step_r[0];
        is_last = (step_r == i2cbb_pkg::READ_LAST);
      end
      i2cbb_pkg::CMD_SEND_ACK, i2cbb_pkg::CMD_READ_ACK: begin
        is_scl  = (step_r != 5'd0);
        if (step_r == 5'd0) begin
          pin_val = (q_data.func == i2cbb_pkg::CMD_SEND_ACK) ? q_data.ack : 1'b1;
        end else begin
          pin_val = (step_r == 5'd1);
        end
        is_last = (step_r == i2cbb_pkg::ACK_LAST);
      end
      default: begin
        is_scl  = 1'b0;
        pin_val = 1'b1;
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    tx_sh_nxt     = tx_sh_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    rx_nxt        = rx_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_pin.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (is_scl) begin
        scl_nxt = pin_val;
      end else begin
        sda_nxt = pin_val;
      end
      last_nxt  = is_last;
      rx_nxt    = is_last ? q_data.rx : 8'd0;
      tx_sh_nxt = (phase_r == 2'd2) ? {tx_sel[6:0], 1'b0} : tx_sel;
      if (is_last) begin
        step_nxt  = 5'd0;
        phase_nxt = 2'd0;
      end else begin
        step_nxt  = step_r + 5'd1;
        phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 5'd0;
      phase_r     <= 2'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_sh_r <= tx_sh_nxt;
    rx_r    <= rx_nxt;
    last_r  <= last_nxt;
  end

  assign pop               = fire && is_last;
  assign out_pin.valid     = out_valid_r;
  assign out_pin.scl_level = scl_r;
  assign out_pin.sda_level = sda_r;
  assign out_pin.rx_data   = rx_r;
  assign out_pin.last      = last_r;

endmodule
`default_nettype wire

// File: sv/i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | modport | payload
// in_cmd    | in  | sink    | func[2:0] tx_byte[7:0] ack_out sda_samples[7:0]
// out_pin   | out | source  | scl_level sda_level rx_data[7:0] last
//
// one pin write leaves per cycle while out_pin does not stall; a command
// makes 3 pin writes (stop, acks), 4 (start), 17 (read byte), 24 (write byte)
// the pin sequencer in the back end sets the counts; commands follow with no gap
// reset: scl and sda read back high, queue empty, no transfer pending
// a stall on out_pin holds the output register; the queue keeps taking commands
// until full, and codes 6 and 7 are taken and dropped without output
module i2c_master_bit_sequencer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  i2cbb_cmd_if.sink    in_cmd,
  i2cbb_pin_if.source  out_pin
);

  // front to back command queue
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  i2cbb_pkg::cmd_t q_in;
  i2cbb_pkg::cmd_t q_out;

  // front end: classify, form receive data, drop undefined codes
  i2cbb_front u_front (
    .in_cmd    (in_cmd),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  i2cbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_out)
  );

  // back end: steps through pin writes, keeps the pin levels
  i2cbb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_out),
    .pop     (q_pop),
    .out_pin (out_pin)
  );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  // codes 6 and 7 are not commands; the block takes and drops them
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int RANDOM_CMDS  = 440;   // commands that make pin writes
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 40;    // settle time after the last pin write
  localparam int DIR_ROWS     = 24;

  // one expected pin write
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       last;
  } pin_write_t;

  // one directed command; rx_want is typed in where it is plain to see
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx;
    logic       ack;
    logic [7:0] smp;
    bit         pin_rx;
    logic [7:0] rx_want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cbb_cmd_if cmd_ch ();
  i2cbb_pin_if pin_ch ();

  i2c_master_bit_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_ch),
    .out_pin(pin_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state: pin levels as the bus master drives them
  logic       scl_model;
  logic       sda_model;
  pin_write_t pin_expect_q[$];

  int  mismatches = 0;
  int  cmds_sent  = 0;   // commands that make pin writes
  bit  hold_out   = 1'b0; // request for a long stall on out_pin
  bit  no_idle    = 1'b0; // stretch with no gaps on either side
  bit  tb_done    = 1'b0;
  int  quiet_cycles = 0;

  // directed commands: bus extremes, every command, ignored codes,
  // repeated start, double stop, ack and read after stop
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{i2cbb_pkg::CMD_START,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_WRITE,    8'h00, 1'b1, 8'hff, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ_ACK, 8'hff, 1'b1, 8'h80, 1'b1, 8'h01},
    '{i2cbb_pkg::CMD_WRITE,    8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ_ACK, 8'h00, 1'b0, 8'h7f, 1'b1, 8'h00},
    '{i2cbb_pkg::CMD_WRITE,    8'ha5, 1'b1, 8'h5a, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ_ACK, 8'h3c, 1'b0, 8'hff, 1'b1, 8'h01},
    '{i2cbb_pkg::CMD_START,    8'hff, 1'b1, 8'hff, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_WRITE,    8'h5a, 1'b0, 8'ha5, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ,     8'hff, 1'b1, 8'h00, 1'b1, 8'h00},
    '{i2cbb_pkg::CMD_SEND_ACK, 8'hff, 1'b0, 8'hff, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ,     8'h00, 1'b0, 8'hff, 1'b1, 8'hff},
    '{i2cbb_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ,     8'hc3, 1'b1, 8'h5a, 1'b1, 8'h5a},
    '{i2cbb_pkg::CMD_SEND_ACK, 8'h81, 1'b0, 8'h18, 1'b0, 8'h00},
    '{CMD_RSVD6,               8'hff, 1'b1, 8'hff, 1'b0, 8'h00},
    '{CMD_RSVD7,               8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ_ACK, 8'hff, 1'b1, 8'h00, 1'b1, 8'h00},
    '{i2cbb_pkg::CMD_STOP,     8'hff, 1'b1, 8'hff, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_STOP,     8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_READ,     8'h00, 1'b0, 8'ha5, 1'b1, 8'ha5},
    '{i2cbb_pkg::CMD_START,    8'h7e, 1'b0, 8'h81, 1'b0, 8'h00},
    '{i2cbb_pkg::CMD_STOP,     8'h81, 1'b1, 8'h7e, 1'b0, 8'h00}
  };

  // one pin write: update the driven level, queue what the bus shows
  function automatic void drive_pin(input bit is_scl, input logic level);
    pin_write_t pw;
    if (is_scl) begin
      scl_model = level;
    end else begin
      sda_model = level;
    end
    pw.scl  = scl_model;
    pw.sda  = sda_model;
    pw.rx   = 8'h00;
    pw.last = 1'b0;
    pin_expect_q.push_back(pw);
  endfunction

  // closes a command: flag the final pin write and attach receive data
  function automatic void close_cmd(input logic [7:0] rx);
    pin_expect_q[pin_expect_q.size() - 1].rx   = rx;
    pin_expect_q[pin_expect_q.size() - 1].last = 1'b1;
  endfunction

  // expected pin writes of one bus command
  function automatic void predict_pin_writes(input logic [2:0] func, input logic [7:0] tx,
                                             input logic ack, input logic [7:0] smp);
    case (func)
      i2cbb_pkg::CMD_START: begin
        drive_pin(1'b0, 1'b1);
        drive_pin(1'b1, 1'b1);
        drive_pin(1'b0, 1'b0);   // sda falls while scl high
        drive_pin(1'b1, 1'b0);
        close_cmd(8'h00);
      end
      i2cbb_pkg::CMD_STOP: begin
        drive_pin(1'b0, 1'b0);
        drive_pin(1'b1, 1'b1);
        drive_pin(1'b0, 1'b1);   // sda rises while scl high
        close_cmd(8'h00);
      end
      i2cbb_pkg::CMD_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          drive_pin(1'b0, tx[i]);
          drive_pin(1'b1, 1'b1);
          drive_pin(1'b1, 1'b0);
        end
        close_cmd(8'h00);
      end
      i2cbb_pkg::CMD_READ: begin
        drive_pin(1'b0, 1'b1);   // release sda for the slave
        for (int i = 0; i < 8; i++) begin
          drive_pin(1'b1, 1'b1);
          drive_pin(1'b1, 1'b0);
        end
        close_cmd(smp);
      end
      i2cbb_pkg::CMD_SEND_ACK: begin
        drive_pin(1'b0, ack);
        drive_pin(1'b1, 1'b1);
        drive_pin(1'b1, 1'b0);
        close_cmd(8'h00);
      end
      i2cbb_pkg::CMD_READ_ACK: begin
        drive_pin(1'b0, 1'b1);
        drive_pin(1'b1, 1'b1);
        drive_pin(1'b1, 1'b0);
        close_cmd({7'h00, smp[7]});
      end
      default: begin
        // undefined codes leave the pins alone
      end
    endcase
  endfunction

  // half the time back to back, otherwise mostly a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one command and wait for its transfer; valid stays high when
  // the next command follows with no gap
  task automatic issue_cmd(input logic [2:0] func, input logic [7:0] tx, input logic ack,
                           input logic [7:0] smp, input bit pin_rx, input logic [7:0] rx_want);
    int gap;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= func;
    cmd_ch.tx_byte     <= tx;
    cmd_ch.ack_out     <= ack;
    cmd_ch.sda_samples <= smp;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_pin_writes(func, tx, ack, smp);
    if (pin_rx) pin_expect_q[pin_expect_q.size() - 1].rx = rx_want;
    if (func <= i2cbb_pkg::CMD_READ_ACK) cmds_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_cmd(input logic [2:0] func);
    issue_cmd(func, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, 8'h00);
  endtask

  // a well-formed bus transaction: start, address, ack, data bytes with
  // acks, sometimes a repeated start in between, then most times a stop
  task automatic bus_transaction();
    logic [7:0] addr;
    int         nbytes;
    addr   = 8'($urandom);
    nbytes = $urandom_range(0, 4);
    random_cmd(i2cbb_pkg::CMD_START);
    issue_cmd(i2cbb_pkg::CMD_WRITE, addr, 1'($urandom), 8'($urandom), 1'b0, 8'h00);
    random_cmd(i2cbb_pkg::CMD_READ_ACK);
    for (int b = 0; b < nbytes; b++) begin
      if (addr[0]) begin
        random_cmd(i2cbb_pkg::CMD_READ);
        random_cmd(i2cbb_pkg::CMD_SEND_ACK);
      end else begin
        random_cmd(i2cbb_pkg::CMD_WRITE);
        random_cmd(i2cbb_pkg::CMD_READ_ACK);
      end
    end
    if ($urandom_range(0, 4) == 0) random_cmd(i2cbb_pkg::CMD_START);
    if ($urandom_range(0, 9) != 0) random_cmd(i2cbb_pkg::CMD_STOP);
  endtask

  // stimulus: reset, directed rows, then random transactions and noise
  initial begin
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;
    scl_model = 1'b1;   // bus idles high after reset
    sda_model = 1'b1;
    rst_n              <= 1'b0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= i2cbb_pkg::CMD_START;
    cmd_ch.tx_byte     <= 8'h00;
    cmd_ch.ack_out     <= 1'b0;
    cmd_ch.sda_samples <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].func, dir_rows[i].tx, dir_rows[i].ack, dir_rows[i].smp,
                dir_rows[i].pin_rx, dir_rows[i].rx_want);
    end

    while (cmds_sent < RANDOM_CMDS) begin
      // occasional stretch with no idling on either side
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 8) begin
        bus_transaction();
      end else begin
        random_cmd(3'($urandom_range(0, 7)));
      end
      // receiver stalls for a long time while commands keep coming
      if (!held && cmds_sent > 150) begin
        held     = 1'b1;
        hold_out = 1'b1;
      end
      // sender waits until every pin write has come back
      if (!drained && cmds_sent > 300) begin
        drained = 1'b1;
        cmd_ch.valid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge clk);
      end
    end
    no_idle = 1'b0;

    cmd_ch.valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tb_done = 1'b1;
    if (mismatches == 0) begin
      $display("[i2c_master_bit_sequencer_core] OK");
    end else begin
      $display("[i2c_master_bit_sequencer_core] ERROR");
    end
    $finish;
  end

  // receiver: random stalls, plus the one long hold-off on request
  initial begin
    int gap;
    pin_ch.ready <= 1'b0;
    forever begin
      if (hold_out) begin
        pin_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          pin_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pin_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // compare each pin write transfer with the oldest expectation
  always @(posedge clk) begin
    pin_write_t want;
    if (rst_n && pin_ch.valid && pin_ch.ready) begin
      if (pin_expect_q.size() == 0) begin
        $display("%0t unexpected pin write: scl %b sda %b rx %h last %b", $realtime,
                 pin_ch.scl_level, pin_ch.sda_level, pin_ch.rx_data, pin_ch.last);
        mismatches++;
      end else begin
        want = pin_expect_q.pop_front();
        if (pin_ch.scl_level !== want.scl) begin
          $display("%0t scl_level: expected %b, got %b", $realtime, want.scl,
                   pin_ch.scl_level);
          mismatches++;
        end
        if (pin_ch.sda_level !== want.sda) begin
          $display("%0t sda_level: expected %b, got %b", $realtime, want.sda,
                   pin_ch.sda_level);
          mismatches++;
        end
        if (pin_ch.rx_data !== want.rx) begin
          $display("%0t rx_data: expected %h, got %h", $realtime, want.rx, pin_ch.rx_data);
          mismatches++;
        end
        if (pin_ch.last !== want.last) begin
          $display("%0t last: expected %b, got %b", $realtime, want.last, pin_ch.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no transfer on either channel ends the run
  always @(posedge clk) begin
    if (rst_n && !tb_done) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (pin_ch.valid && pin_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no transfer for %0d cycles, %0d pin writes outstanding",
                 $realtime, quiet_cycles, pin_expect_q.size());
        $display("[i2c_master_bit_sequencer_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sim.f
sv/i2cbb_pkg.sv
sv/i2cbb_if.sv
sv/i2cbb_front.sv
sv/i2cbb_queue.sv
sv/i2cbb_back.sv
sv/i2c_master_bit_sequencer_core.sv
verif/testbench.sv
